/* rtl/core/top_k_largest_tracker_macros.svh */
// Assertion macros for the top-K tracker.
// Used by top_k_largest_tracker.sv; needs nothing else.
`ifndef TOP_K_LARGEST_TRACKER_MACROS_SVH
`define TOP_K_LARGEST_TRACKER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TKL_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TKL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/tkl_pkg.sv */
// Shared types and widths for the top-K tracker.
// No dependencies; used by every module of the block.
package tkl_pkg;

	localparam int KEY_W   = 12;
	localparam int COUNT_W = 31;

	// One incoming request.
	typedef struct packed {
		logic [KEY_W-1:0]   item_key;
		logic [COUNT_W-1:0] item_count;
		logic               last_item;
	} item_t;

	// One ranked result.
	typedef struct packed {
		logic [KEY_W-1:0]   out_key;
		logic [COUNT_W-1:0] out_count;
		logic               out_last;
	} result_t;

	// One kept entry of the ranking.
	typedef struct packed {
		logic [KEY_W-1:0]   key;
		logic [COUNT_W-1:0] count;
	} entry_t;

endpackage

/* rtl/core/tkl_store.sv */
// Sorted store of the kept entries with its combinational insertion logic.
// Depends on tkl_pkg.
module tkl_store #(
	parameter int TOP_K = 10
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            take,
	input  tkl_pkg::item_t  item,
	output tkl_pkg::entry_t nxt_ent [TOP_K],
	output logic            nxt_vld [TOP_K]
);
	import tkl_pkg::*;

	entry_t     ent_q [TOP_K];
	logic       vld_q [TOP_K];
	logic [TOP_K-1:0] ge;
	logic [TOP_K-1:0] place;
	entry_t     new_ent;

	assign new_ent.key   = item.item_key;
	assign new_ent.count = item.item_count;

	// Entries that rank at or above the new item form a prefix of the store;
	// the item lands right after that prefix and everything below shifts down.
	// A full store whose minimum is not beaten has every entry in the prefix,
	// so nothing changes and the item is dropped.
	for (genvar g = 0; g < TOP_K; g++) begin : g_slot
		assign ge[g] = vld_q[g] && (ent_q[g].count >= item.item_count);
		if (g == 0) begin : g_head
			assign place[g]   = !ge[g];
			assign nxt_ent[g] = ge[g] ? ent_q[g] : new_ent;
			assign nxt_vld[g] = vld_q[g] || place[g];
		end else begin : g_body
			assign place[g]   = !ge[g] && ge[g-1];
			assign nxt_ent[g] = ge[g] ? ent_q[g] : (place[g] ? new_ent : ent_q[g-1]);
			// A slot also turns valid when a valid entry shifts down into it.
			assign nxt_vld[g] = vld_q[g] || place[g] || vld_q[g-1];
		end
	end

	// Valid bits: a last item hands the list to the drain and empties the store.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TOP_K; i++) vld_q[i] <= 1'b0;
		end else if (take) begin
			for (int i = 0; i < TOP_K; i++) vld_q[i] <= item.last_item ? 1'b0 : nxt_vld[i];
		end
	end

	// Entry payload.
	always_ff @(posedge clk) begin
		if (take) begin
			for (int i = 0; i < TOP_K; i++) ent_q[i] <= nxt_ent[i];
		end
	end

endmodule

/* rtl/core/tkl_drain.sv */
// Result buffer that emits a captured ranking one entry per accepted result.
// Depends on tkl_pkg.
module tkl_drain #(
	parameter int TOP_K = 10
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  tkl_pkg::entry_t  ent_in [TOP_K],
	input  logic             vld_in [TOP_K],
	output logic             res_valid,
	input  logic             res_stall,
	output tkl_pkg::result_t res,
	output logic             free
);
	import tkl_pkg::*;

	entry_t ent_q [TOP_K];
	logic   vld_q [TOP_K];
	logic   fire;
	logic   more;

	assign fire = vld_q[0] && !res_stall;

	// Another entry behind the head means the head is not the final result.
	if (TOP_K > 1) begin : g_more
		assign more = vld_q[1];
	end else begin : g_one
		assign more = 1'b0;
	end

	assign res_valid     = vld_q[0];
	assign res.out_key   = ent_q[0].key;
	assign res.out_count = ent_q[0].count;
	assign res.out_last  = !more;
	assign free          = !vld_q[0];

	// Valid bits: capture on load, shift toward the head on each request taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TOP_K; i++) vld_q[i] <= 1'b0;
		end else if (load) begin
			for (int i = 0; i < TOP_K; i++) vld_q[i] <= vld_in[i];
		end else if (fire) begin
			for (int i = 0; i < TOP_K - 1; i++) vld_q[i] <= vld_q[i+1];
			vld_q[TOP_K-1] <= 1'b0;
		end
	end

	// Entry payload follows the same moves.
	always_ff @(posedge clk) begin
		if (load) begin
			for (int i = 0; i < TOP_K; i++) ent_q[i] <= ent_in[i];
		end else if (fire) begin
			for (int i = 0; i < TOP_K - 1; i++) ent_q[i] <= ent_q[i+1];
		end
	end

endmodule

/* rtl/core/top_k_largest_tracker.sv */
// Top-K tracker: keeps the TOP_K largest counts of a stream with their keys.
// Channels: item (key, count, last_item) in, result (key, count, out_last) out,
// each a valid/stall handshake; a request moves when valid is high and stall low.
// Every item is registered once, then inserted into a sorted store by one
// parallel compare against all kept entries and a shift. An item marked last
// is inserted like any other; the finished ranking is then copied into an
// output buffer and the store is emptied for the next set. Results leave
// largest count first, one per cycle while the receiver does not stall,
// out_last on the final one; ties keep arrival order. The first result of a
// set becomes valid once its last item has passed the input register and
// loaded the buffer. Throughput: one item per cycle while item stall is low.
// A set of n kept entries drains one entry per accepted result; a later last
// item waits in the input register until the buffer is empty, and stall goes
// high on the item side meanwhile. Items that are not last keep flowing while
// a list drains. A stalled result holds in the buffer.
// Reset empties the store, the input register and the buffer at once.
// Depends on tkl_pkg, tkl_store, tkl_drain and the assertion macro header.
`include "top_k_largest_tracker_macros.svh"

module top_k_largest_tracker #(
	parameter int TOP_K = 10
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_stall,
	input  tkl_pkg::item_t   item,
	output logic             res_valid,
	input  logic             res_stall,
	output tkl_pkg::result_t res
);
	import tkl_pkg::*;

	item_t  item_s1;
	logic   valid_s1;
	logic   take;
	logic   accept;
	logic   drain_free;
	entry_t nxt_ent [TOP_K];
	logic   nxt_vld [TOP_K];

	// The registered item moves on unless it is last and the buffer is busy.
	assign take       = valid_s1 && (!item_s1.last_item || drain_free);
	assign item_stall = valid_s1 && !take;
	assign accept     = item_valid && !item_stall;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item;
		end
	end

	// Sorted store with insertion.
	tkl_store #(
		.TOP_K(TOP_K)
	) u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (take),
		.item   (item_s1),
		.nxt_ent(nxt_ent),
		.nxt_vld(nxt_vld)
	);

	// Output buffer, loaded with the ranking that includes the last item.
	tkl_drain #(
		.TOP_K(TOP_K)
	) u_drain (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (take && item_s1.last_item),
		.ent_in   (nxt_ent),
		.vld_in   (nxt_vld),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res      (res),
		.free     (drain_free)
	);

	// A last item only enters the buffer while no list is being drained.
	`TKL_ASSERT_NOW(a_load_when_free, clk, arst_n, take && item_s1.last_item, !res_valid, "last item loaded over a pending list")
	// A loaded list always has at least one result to show.
	`TKL_ASSERT_NEXT(a_list_nonempty, clk, arst_n, take && item_s1.last_item, res_valid, "last item produced no result")
	// The item side only stalls behind a last item waiting for the buffer.
	`TKL_ASSERT_NOW(a_stall_cause, clk, arst_n, item_stall, valid_s1 && item_s1.last_item && res_valid, "item stall without a busy buffer")

endmodule

/* tb/top_k_largest_tracker_tb.sv */
// Self-checking testbench for the top-K tracker: random and directed sets of
// requests, a leaderboard predictor and an in-order check of every ranked result.
// Depends on tkl_pkg and top_k_largest_tracker.
`timescale 1ns / 100ps

module top_k_largest_tracker_tb;

	import tkl_pkg::*;

	localparam int RANK_DEPTH  = 10;
	localparam int HOLD_CYCLES = 80;
	localparam int FULL_SPREAD = 0;

	logic    clk;
	logic    arst_n     = 1'b0;
	logic    item_valid = 1'b0;
	logic    item_stall;
	item_t   item       = '0;
	logic    res_valid;
	logic    res_stall  = 1'b0;
	result_t res;

	// Requests waiting to be offered, and results the leaderboard says must come.
	item_t   pending_items[$];
	result_t expected_ranking[$];

	// Leaderboard kept by the predictor, sorted by descending count.
	bit [COUNT_W-1:0] board_count[RANK_DEPTH];
	bit [KEY_W-1:0]   board_key[RANK_DEPTH];
	int               board_size = 0;

	int  items_queued    = 0;
	int  items_accepted  = 0;
	int  error_count     = 0;
	int  sender_idle_pct = 0;
	int  recv_stall_pct  = 0;
	bit  item_taken      = 1'b0;
	bit  long_hold       = 1'b0;
	bit  hold_armed      = 1'b0;
	int  hold_left       = 0;

	top_k_largest_tracker #(
		.TOP_K(RANK_DEPTH)
	) DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item      (item),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Insert one request into the leaderboard; a last request releases the ranking.
	task automatic rank_item(input item_t it);
		int      slot;
		int      tail;
		bit      admit;
		result_t r;
		slot  = 0;
		tail  = 0;
		admit = 1'b1;
		while (slot < board_size && board_count[slot] >= it.item_count)
			slot++;
		if (board_size < RANK_DEPTH) begin
			tail = board_size;
			board_size++;
		end else if (it.item_count <= board_count[RANK_DEPTH-1]) begin
			// A full board drops anything not strictly above its minimum.
			admit = 1'b0;
		end else begin
			tail = RANK_DEPTH - 1;
		end
		if (admit) begin
			for (int i = tail; i > slot; i--) begin
				board_count[i] = board_count[i-1];
				board_key[i]   = board_key[i-1];
			end
			board_count[slot] = it.item_count;
			board_key[slot]   = it.item_key;
		end
		if (it.last_item) begin
			for (int k = 0; k < board_size; k++) begin
				r.out_key   = board_key[k];
				r.out_count = board_count[k];
				r.out_last  = (k == board_size - 1);
				expected_ranking.push_back(r);
			end
			board_size = 0;
		end
	endtask

	// Request driver: a new request only once the previous one has been taken.
	always @(negedge clk) begin
		if (item_taken || !item_valid) begin
			if (pending_items.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
				item       <= pending_items.pop_front();
				item_valid <= 1'b1;
			end else begin
				item_valid <= 1'b0;
			end
		end
	end

	// Result receiver: random stalls plus one long hold-off counted here.
	always @(negedge clk) begin
		if (long_hold && !hold_armed) begin
			hold_armed <= 1'b1;
			hold_left  <= HOLD_CYCLES;
			res_stall  <= 1'b1;
		end else begin
			if (hold_left != 0)
				hold_left <= hold_left - 1;
			res_stall <= (hold_left > 1) || ($urandom_range(99) < recv_stall_pct);
		end
	end

	// Monitor: feed accepted requests to the predictor and check every result.
	always @(posedge clk) begin
		result_t want;
		item_taken <= arst_n && item_valid && !item_stall;
		if (arst_n) begin
			if (item_valid && !item_stall) begin
				rank_item(item);
				items_accepted++;
			end
			if (res_valid && !res_stall) begin
				if (expected_ranking.size() == 0) begin
					$error("unexpected result: key %0d count %0d last %0b",
						res.out_key, res.out_count, res.out_last);
					error_count++;
				end else begin
					want = expected_ranking.pop_front();
					if (res.out_key !== want.out_key) begin
						$error("out_key: expected %0d, got %0d", want.out_key, res.out_key);
						error_count++;
					end
					if (res.out_count !== want.out_count) begin
						$error("out_count: expected %0d, got %0d",
							want.out_count, res.out_count);
						error_count++;
					end
					if (res.out_last !== want.out_last) begin
						$error("out_last: expected %0b, got %0b", want.out_last, res.out_last);
						error_count++;
					end
				end
			end
		end
	end

	task automatic queue_item(input int key, input int unsigned count, input bit last);
		item_t it;
		it.item_key   = KEY_W'(key);
		it.item_count = COUNT_W'(count);
		it.last_item  = last;
		pending_items.push_back(it);
		items_queued++;
	endtask

	// One set of random requests, closed by a last request. A spread of zero
	// draws counts over the full range; a small spread forces many ties.
	task automatic queue_set(input int len, input int spread);
		int unsigned count;
		for (int i = 0; i < len; i++) begin
			if (spread == FULL_SPREAD)
				count = $urandom() & 32'h7FFF_FFFF;
			else
				count = $urandom_range(spread);
			queue_item($urandom_range(4095), count, i == len - 1);
		end
	endtask

	// Random sets until about the given number of requests is queued.
	task automatic queue_random_sets(input int total);
		int done;
		int len;
		done = 0;
		while (done < total) begin
			len = $urandom_range(1, 20);
			queue_set(len, ($urandom_range(2) == 0) ? FULL_SPREAD : $urandom_range(1, 15));
			done += len;
		end
	endtask

	// Pause the sender until every queued request is taken and every result is in.
	task automatic wait_drain();
		do
			@(negedge clk);
		while (items_accepted != items_queued || expected_ranking.size() != 0);
	endtask

	task automatic run_phase(input int idle_pct, input int stall_pct, input int total);
		@(posedge clk);
		sender_idle_pct = idle_pct;
		recv_stall_pct  = stall_pct;
		queue_random_sets(total);
		wait_drain();
	endtask

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed sets: field extremes, ties, equal-to-minimum drop and eviction.
		@(posedge clk);
		queue_item(0, 0, 1'b1);
		queue_item(4095, 32'h7FFF_FFFF, 1'b1);
		for (int k = 1; k <= RANK_DEPTH; k++)
			queue_item(k, 5, 1'b0);
		queue_item(200, 5, 1'b0);
		queue_item(300, 6, 1'b0);
		queue_item(400, 0, 1'b1);
		queue_item(12'hAAA, 32'h2AAA_AAAA, 1'b0);
		queue_item(12'h555, 32'h5555_5555, 1'b0);
		queue_item(7, 9, 1'b0);
		queue_item(8, 3, 1'b0);
		queue_item(9, 3, 1'b1);
		wait_drain();

		// Random sets under the different idling patterns.
		run_phase(0, 0, 16);
		run_phase(65, 0, 16);
		run_phase(0, 65, 16);
		run_phase(33, 33, 16);

		// Long receiver hold-off while the sender keeps offering full sets,
		// so the output buffer fills and a later last request backs up.
		@(posedge clk);
		sender_idle_pct = 0;
		recv_stall_pct  = 0;
		long_hold       = 1'b1;
		queue_set(12, 8);
		queue_set(5, FULL_SPREAD);
		queue_set(8, 4);
		wait_drain();

		repeat (20) @(negedge clk);
		if (error_count == 0 && expected_ranking.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin
		#2_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule
